### rtl/core/ambs_pkg.sv
// Shared types and constants for the adaptive median background subtractor.
// Field widths, register codes, mode codes and shadow test limits.
// No dependencies.
`default_nettype none

package ambs_pkg;

  localparam int COLOR_W       = 8;
  localparam int PIXEL_INDEX_W = 17;
  localparam int FRAME_W       = 16;
  localparam int MODE_W        = 2;
  localparam int THR_W         = 8;
  localparam int RATE_W        = 8;
  localparam int LEARN_W       = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam int DEF_MAX_PIXELS = 131072;

  // Frame remainder pipeline: bits of the frame number resolved per stage.
  localparam int MOD_BITS   = 4;
  localparam int MOD_STAGES = FRAME_W / MOD_BITS;

  // Shadow test arithmetic.
  localparam int DOT_W             = 2 * COLOR_W + 2;
  localparam int PROD_W            = 2 * DOT_W;
  localparam int LIMIT_W           = DOT_W + 7;
  localparam int SHADOW_DIST_LIMIT = 70;
  localparam int BD_LOW_NUM        = 3;
  localparam int BD_LOW_DEN        = 10;

  localparam logic [THR_W-1:0]   RST_LOW_THRESHOLD   = THR_W'(20);
  localparam logic [RATE_W-1:0]  RST_SAMPLING_RATE   = RATE_W'(2);
  localparam logic [LEARN_W-1:0] RST_LEARNING_FRAMES = LEARN_W'(30);

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_LOW_THRESHOLD   = cfg_index_t'(0);
  localparam cfg_index_t CFG_SAMPLING_RATE   = cfg_index_t'(1);
  localparam cfg_index_t CFG_LEARNING_FRAMES = cfg_index_t'(2);

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_LOAD     = mode_t'(0);
  localparam mode_t MODE_SUBTRACT = mode_t'(1);
  localparam mode_t MODE_UPDATE   = mode_t'(2);

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    mode_t  mode;
    logic   in_range;
    logic   upd_allowed;
    pixel_t pix;
  } item_t;

endpackage

`default_nettype wire

### rtl/core/ambs_frame_mod.sv
// Pipelined remainder of frame number by sampling rate, a few bits per stage.
// Flags frames whose remainder is one. Depends on ambs_pkg.
`default_nettype none

module ambs_frame_mod import ambs_pkg::*; (
  input  wire                 clk_i,
  input  wire                 en_i,
  input  wire [FRAME_W-1:0]   frame_i,
  input  wire [RATE_W-1:0]    rate_i,
  output logic                sample_o
);

  function automatic logic [RATE_W-1:0] rem_steps(input logic [RATE_W-1:0]   rem,
                                                  input logic [MOD_BITS-1:0] bits,
                                                  input logic [RATE_W-1:0]   div);
    logic [RATE_W:0]   t;
    logic [RATE_W-1:0] r;
    r = rem;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[RATE_W-1:0];
    end
    return r;
  endfunction

  logic [RATE_W-1:0]  rem_q [MOD_STAGES];
  logic [FRAME_W-1:0] frm_q [MOD_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_steps('0, frame_i[FRAME_W-1 -: MOD_BITS], rate_i);
      frm_q[0] <= frame_i;
      for (int j = 1; j < MOD_STAGES; j++) begin
        rem_q[j] <= rem_steps(rem_q[j-1], frm_q[j-1][FRAME_W-1-j*MOD_BITS -: MOD_BITS],
                              rate_i);
      end
      for (int j = 1; j < MOD_STAGES - 1; j++) begin
        frm_q[j] <= frm_q[j-1];
      end
    end
  end

  // A zero rate never samples.
  assign sample_o = (rate_i != '0) && (rem_q[MOD_STAGES-1] == RATE_W'(1));

endmodule

`default_nettype wire

### rtl/core/ambs_model_mem.sv
// Background model memory: one read and one write port, registered read data.
// Forwards a write that lands on the entry read in the same cycle. Depends on ambs_pkg.
`default_nettype none

module ambs_model_mem import ambs_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_PIXELS,
  parameter int ADDR_W = PIXEL_INDEX_W
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               rd_en_i,
  input  wire [ADDR_W-1:0]  rd_addr_i,
  input  wire               wr_en_i,
  input  wire [ADDR_W-1:0]  wr_addr_i,
  input  pixel_t            wr_data_i,
  output pixel_t            rd_data_o
);

  pixel_t mem_q [DEPTH];
  pixel_t rdata_q;
  pixel_t fwd_data_q;
  logic   fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

### rtl/core/ambs_classify.sv
// Threshold and shadow classification: dot products, then products, then compare.
// Two register stages; results read from the second. Depends on ambs_pkg.
`default_nettype none

module ambs_classify import ambs_pkg::*; (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire              sub_i,
  input  pixel_t           pix_i,
  input  pixel_t           model_i,
  input  wire [THR_W-1:0]  thr_i,
  output logic             fg_o,
  output logic             sh_o
);

  function automatic logic [DOT_W-1:0] dot3(input pixel_t a, input pixel_t b);
    logic [2*COLOR_W-1:0] pr;
    logic [2*COLOR_W-1:0] pg;
    logic [2*COLOR_W-1:0] pb;
    pr = a.r * b.r;
    pg = a.g * b.g;
    pb = a.b * b.b;
    return DOT_W'(pr) + DOT_W'(pg) + DOT_W'(pb);
  endfunction

  function automatic logic [COLOR_W-1:0] absdiff(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [DOT_W-1:0]   p_q, q_q, ff_q;
  logic               bg_q, sub_q;
  logic [PROD_W-1:0]  qff_q, psq_q;
  logic [LIMIT_W-1:0] q70_q;
  logic               pre_q, bg2_q, sub2_q;

  logic               bg_d;
  logic [DOT_W+3:0]   p10;
  logic [DOT_W+3:0]   q3;
  logic               pre_d;

  always_comb begin
    bg_d = (absdiff(pix_i.r, model_i.r) <= thr_i) &&
           (absdiff(pix_i.g, model_i.g) <= thr_i) &&
           (absdiff(pix_i.b, model_i.b) <= thr_i);
    p10   = (DOT_W+4)'(p_q) * (DOT_W+4)'(BD_LOW_DEN);
    q3    = (DOT_W+4)'(q_q) * (DOT_W+4)'(BD_LOW_NUM);
    // Brightness ratio strictly between 0.3 and 1, black background excluded.
    pre_d = sub_q && (q_q != '0) && (p_q < q_q) && (p10 > q3);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= dot3(pix_i, model_i);
      q_q    <= dot3(model_i, model_i);
      ff_q   <= dot3(pix_i, pix_i);
      bg_q   <= bg_d;
      sub_q  <= sub_i;
      qff_q  <= PROD_W'(q_q) * PROD_W'(ff_q);
      psq_q  <= PROD_W'(p_q) * PROD_W'(p_q);
      q70_q  <= LIMIT_W'(q_q) * LIMIT_W'(SHADOW_DIST_LIMIT);
      pre_q  <= pre_d;
      bg2_q  <= bg_q;
      sub2_q <= sub_q;
    end
  end

  // Q*|f|^2 >= P^2 always, so the difference never wraps.
  assign sh_o = pre_q && ((qff_q - psq_q) < PROD_W'(q70_q));
  assign fg_o = sub2_q && !bg2_q && !sh_o;

endmodule

`default_nettype wire

### rtl/core/adaptive_median_background_subtract.sv
// Per-pixel approximate median background subtraction with a shadow test. One
// pixel is taken per cycle while in_stall_o is low, and every pixel gives one
// result: four stages resolve frame_number modulo sampling_rate, one stage
// reads the model entry, one stage forms the dot products and one the
// products of the shadow test. The model memory (MAX_PIXELS entries of 24 bits)
// does one read and one write per cycle, which sets the rate at one pixel per
// cycle; a write and a read of the same entry in one cycle are forwarded.
// Entries hold nothing useful until a load writes them; there is no clearing.
// An output register with a one-entry skid stage keeps the input open while a
// result waits; in_stall_o rises only when the skid stage is full.
`default_nettype none

module adaptive_median_background_subtract import ambs_pkg::*; #(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire [CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire [MODE_W-1:0]         mode_i,
  input  wire [PIXEL_INDEX_W-1:0]  pixel_index_i,
  input  wire [COLOR_W-1:0]        red_i,
  input  wire [COLOR_W-1:0]        green_i,
  input  wire [COLOR_W-1:0]        blue_i,
  input  wire [FRAME_W-1:0]        frame_number_i,
  input  wire                      update_is_background_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic                     foreground_o,
  output logic                     shadow_o
);

  localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CMP_W   = ((ADDR_W > PIXEL_INDEX_W) ? ADDR_W : PIXEL_INDEX_W) + 1;
  localparam int X_STAGE = MOD_STAGES;
  localparam int LAST    = MOD_STAGES + 2;
  localparam int NSTAGE  = MOD_STAGES + 3;

  function automatic logic [COLOR_W-1:0] step_toward(input logic [COLOR_W-1:0] m,
                                                     input logic [COLOR_W-1:0] p);
    logic [COLOR_W-1:0] r;
    r = m;
    if (p > m) begin
      r = m + COLOR_W'(1);
    end else if (p < m) begin
      r = m - COLOR_W'(1);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [THR_W-1:0]   thr_q;
  logic [RATE_W-1:0]  rate_q;
  logic [LEARN_W-1:0] learn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= RST_LOW_THRESHOLD;
      rate_q  <= RST_SAMPLING_RATE;
      learn_q <= RST_LEARNING_FRAMES;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOW_THRESHOLD:   thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_SAMPLING_RATE:   rate_q  <= cfg_data_i[RATE_W-1:0];
        CFG_LEARNING_FRAMES: learn_q <= cfg_data_i[LEARN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic              skid_q;
  logic              adv;
  logic              accept;
  logic [NSTAGE-1:0] v_q;

  assign adv        = !skid_q;
  assign in_stall_o = skid_q;
  assign accept     = in_valid_i && !skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTAGE-2:0], accept};
    end
  end

  // Input item.
  logic [CMP_W-1:0] idx_ext;
  item_t            item_d;

  always_comb begin
    idx_ext            = CMP_W'(pixel_index_i);
    item_d.mode        = mode_i;
    item_d.in_range    = idx_ext < CMP_W'(MAX_PIXELS);
    item_d.upd_allowed = update_is_background_i || (frame_number_i < learn_q);
    item_d.pix         = {red_i, green_i, blue_i};
  end

  // Front stages run alongside the remainder pipeline.
  item_t             s_item_q [MOD_STAGES];
  logic [ADDR_W-1:0] s_addr_q [MOD_STAGES];
  logic              sample;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_item_q[0] <= item_d;
      s_addr_q[0] <= idx_ext[ADDR_W-1:0];
      for (int j = 1; j < MOD_STAGES; j++) begin
        s_item_q[j] <= s_item_q[j-1];
        s_addr_q[j] <= s_addr_q[j-1];
      end
    end
  end

  ambs_frame_mod u_frame_mod (
    .clk_i    (clk_i),
    .en_i     (adv),
    .frame_i  (frame_number_i),
    .rate_i   (rate_q),
    .sample_o (sample)
  );

  // Model read at the end of the front stages; data arrives with stage X.
  item_t             x_item_q;
  logic [ADDR_W-1:0] x_addr_q;
  logic              x_sample_q;
  pixel_t            mem_rdata;
  pixel_t            model;
  pixel_t            wr_data;
  logic              wr_req;
  logic              wr_en;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_item_q   <= s_item_q[MOD_STAGES-1];
      x_addr_q   <= s_addr_q[MOD_STAGES-1];
      x_sample_q <= sample;
    end
  end

  always_comb begin
    model   = x_item_q.in_range ? mem_rdata : '0;
    wr_req  = 1'b0;
    wr_data = x_item_q.pix;
    case (x_item_q.mode)
      MODE_LOAD: begin
        wr_req = x_item_q.in_range;
      end
      MODE_UPDATE: begin
        wr_req    = x_item_q.in_range && x_sample_q && x_item_q.upd_allowed;
        wr_data.r = step_toward(model.r, x_item_q.pix.r);
        wr_data.g = step_toward(model.g, x_item_q.pix.g);
        wr_data.b = step_toward(model.b, x_item_q.pix.b);
      end
      default: ;
    endcase
    wr_en = adv && v_q[X_STAGE] && wr_req;
  end

  ambs_model_mem #(
    .DEPTH  (MAX_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_model_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv && v_q[MOD_STAGES-1]),
    .rd_addr_i (s_addr_q[MOD_STAGES-1]),
    .wr_en_i   (wr_en),
    .wr_addr_i (x_addr_q),
    .wr_data_i (wr_data),
    .rd_data_o (mem_rdata)
  );

  logic res_fg;
  logic res_sh;

  ambs_classify u_classify (
    .clk_i   (clk_i),
    .en_i    (adv),
    .sub_i   (x_item_q.mode == MODE_SUBTRACT),
    .pix_i   (x_item_q.pix),
    .model_i (model),
    .thr_i   (thr_q),
    .fg_o    (res_fg),
    .sh_o    (res_sh)
  );

  // Output register and skid stage.
  logic out_valid_q, out_fg_q, out_sh_q;
  logic skid_fg_q, skid_sh_q;
  logic take;
  logic incoming;

  assign take     = out_valid_q && !out_stall_i;
  assign incoming = adv && v_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else if (skid_q) begin
      if (take) begin
        skid_q <= 1'b0;
      end
    end else if (incoming) begin
      if (out_valid_q && !take) begin
        skid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_q) begin
      if (take) begin
        out_fg_q <= skid_fg_q;
        out_sh_q <= skid_sh_q;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_fg_q <= res_fg;
        out_sh_q <= res_sh;
      end else begin
        skid_fg_q <= res_fg;
        skid_sh_q <= res_sh;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign foreground_o = out_fg_q;
  assign shadow_o     = out_sh_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("transferred pixel did not enter the pipeline");

  a_frozen_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q && out_stall_i) |=> $stable(v_q))
    else $error("pipeline moved while skid stage full and stalled");

  a_fg_sh_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(foreground_o && shadow_o))
    else $error("foreground and shadow both set");

  a_write_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (x_item_q.in_range && (x_item_q.mode == MODE_LOAD ||
                                     x_item_q.mode == MODE_UPDATE)))
    else $error("model write without a load or update item in range");

endmodule

`default_nettype wire

### sim/tb_adaptive_median_background_subtract.sv
`timescale 1ns / 100ps
// Testbench for adaptive_median_background_subtract: directed and random pixel streams
// with random idling on both sides, checked against a per-pixel background tracker.
// Depends on ambs_pkg and the block's RTL.
module tb_adaptive_median_background_subtract;
  import ambs_pkg::*;

  localparam mode_t MODE_UNUSED    = mode_t'(3);
  localparam int    IDLE_PCT       = 26;
  localparam int    HOLD_CYCLES    = 80;
  localparam int    N_PHASES       = 6;
  localparam int    RAND_PER_PHASE = 72;
  localparam int    POOL_TARGET    = 40;
  localparam int    MAX_PRINTS     = 100;

  typedef struct {
    mode_t                  mode;
    bit [PIXEL_INDEX_W-1:0] index;
    bit [COLOR_W-1:0]       red;
    bit [COLOR_W-1:0]       green;
    bit [COLOR_W-1:0]       blue;
    bit [FRAME_W-1:0]       frame;
    bit                     upd_bg;
  } pix_item_t;

  typedef struct packed {
    bit fg;
    bit sh;
  } pix_label_t;

  // Background memory, register copies and the labels still owed by the block.
  class bgs_tracker;
    bit [3*COLOR_W-1:0] bg_mem [int unsigned];
    bit [THR_W-1:0]     low_thr;
    bit [RATE_W-1:0]    rate;
    bit [LEARN_W-1:0]   learn;
    pix_label_t         label_q [$];
    int                 mismatches;

    function new();
      low_thr    = RST_LOW_THRESHOLD;
      rate       = RST_SAMPLING_RATE;
      learn      = RST_LEARNING_FRAMES;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_index_t idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOW_THRESHOLD:   low_thr = data[THR_W-1:0];
        CFG_SAMPLING_RATE:   rate    = data[RATE_W-1:0];
        CFG_LEARNING_FRAMES: learn   = data[LEARN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [3*COLOR_W-1:0] stored(int unsigned idx);
      return bg_mem.exists(idx) ? bg_mem[idx] : '0;
    endfunction

    function bit [COLOR_W-1:0] absdiff(bit [COLOR_W-1:0] a, bit [COLOR_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function bit [COLOR_W-1:0] step_toward(bit [COLOR_W-1:0] m, bit [COLOR_W-1:0] p);
      if (p > m) return m + 1'b1;
      if (p < m) return m - 1'b1;
      return m;
    endfunction

    // Exact integer form of the brightness and chromaticity test.
    function bit shadow_holds(bit [3*COLOR_W-1:0] f, bit [3*COLOR_W-1:0] b);
      bit [63:0] p, q, ff;
      p  = 64'(f[23:16]) * 64'(b[23:16]) + 64'(f[15:8]) * 64'(b[15:8])
         + 64'(f[7:0]) * 64'(b[7:0]);
      q  = 64'(b[23:16]) * 64'(b[23:16]) + 64'(b[15:8]) * 64'(b[15:8])
         + 64'(b[7:0]) * 64'(b[7:0]);
      ff = 64'(f[23:16]) * 64'(f[23:16]) + 64'(f[15:8]) * 64'(f[15:8])
         + 64'(f[7:0]) * 64'(f[7:0]);
      if (q == 0) return 1'b0;
      if (p >= q) return 1'b0;
      if (64'(BD_LOW_DEN) * p <= 64'(BD_LOW_NUM) * q) return 1'b0;
      return (q * ff - p * p) < 64'(SHADOW_DIST_LIMIT) * q;
    endfunction

    function void accept_pixel(pix_item_t it);
      bit [3*COLOR_W-1:0] m, f;
      pix_label_t         lab;
      bit                 near;
      m   = stored(it.index);
      f   = {it.red, it.green, it.blue};
      lab = '0;
      case (it.mode)
        MODE_LOAD: bg_mem[it.index] = f;
        MODE_SUBTRACT: begin
          near = absdiff(f[23:16], m[23:16]) <= low_thr &&
                 absdiff(f[15:8], m[15:8]) <= low_thr &&
                 absdiff(f[7:0], m[7:0]) <= low_thr;
          lab.sh = shadow_holds(f, m);
          lab.fg = !near && !lab.sh;
        end
        MODE_UPDATE: begin
          if (rate != 0 && it.frame % rate == 1 && (it.upd_bg || it.frame < learn))
            bg_mem[it.index] = {step_toward(m[23:16], f[23:16]),
                                step_toward(m[15:8], f[15:8]),
                                step_toward(m[7:0], f[7:0])};
        end
        default: ;
      endcase
      label_q.push_back(lab);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_label(logic fg, logic sh);
      pix_label_t want;
      if (label_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result fg=%b sh=%b", fg, sh));
        return;
      end
      want = label_q.pop_front();
      if (fg !== want.fg)
        report_mismatch($sformatf("foreground %b, want %b", fg, want.fg));
      if (sh !== want.sh)
        report_mismatch($sformatf("shadow %b, want %b", sh, want.sh));
    endtask
  endclass

  logic                     clk_i                  = 1'b0;
  logic                     rst_ni                 = 1'b0;
  logic                     cfg_we_i               = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index_i            = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i             = '0;
  logic                     in_valid_i             = 1'b0;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        mode_i                 = MODE_LOAD;
  logic [PIXEL_INDEX_W-1:0] pixel_index_i          = '0;
  logic [COLOR_W-1:0]       red_i                  = '0;
  logic [COLOR_W-1:0]       green_i                = '0;
  logic [COLOR_W-1:0]       blue_i                 = '0;
  logic [FRAME_W-1:0]       frame_number_i         = '0;
  logic                     update_is_background_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i            = 1'b0;
  logic                     foreground_o;
  logic                     shadow_o;

  bgs_tracker  tracker;
  int          item_no   = 0;
  bit          no_idle   = 1'b0;
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  int unsigned addr_pool [$];

  adaptive_median_background_subtract #(
    .MAX_PIXELS(DEF_MAX_PIXELS)
  ) u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .mode_i                (mode_i),
    .pixel_index_i         (pixel_index_i),
    .red_i                 (red_i),
    .green_i               (green_i),
    .blue_i                (blue_i),
    .frame_number_i        (frame_number_i),
    .update_is_background_i(update_is_background_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .foreground_o          (foreground_o),
    .shadow_o              (shadow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Sample at the falling edge; the transfer happens at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      tracker.check_label(foreground_o, shadow_o);
  end

  function automatic bit [COLOR_W-1:0] clamp8(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic bit [COLOR_W-1:0] jitter(bit [COLOR_W-1:0] c, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    return clamp8(int'(c) + d);
  endfunction

  function automatic pix_item_t mk(mode_t mode, int unsigned idx, int r, int g, int b,
                                   int frame, bit upd_bg);
    pix_item_t it;
    it.mode   = mode;
    it.index  = idx[PIXEL_INDEX_W-1:0];
    it.red    = r[7:0];
    it.green  = g[7:0];
    it.blue   = b[7:0];
    it.frame  = frame[FRAME_W-1:0];
    it.upd_bg = upd_bg;
    return it;
  endfunction

  // Any mode; subtract ones near the stored value, scaled-down shadows, or plain noise.
  function automatic pix_item_t make_random_item();
    pix_item_t          it;
    bit [3*COLOR_W-1:0] b;
    int                 kind, pick, n, thr, k;
    it.index  = PIXEL_INDEX_W'(addr_pool[$urandom_range(0, addr_pool.size() - 1)]);
    it.red    = COLOR_W'($urandom);
    it.green  = COLOR_W'($urandom);
    it.blue   = COLOR_W'($urandom);
    it.frame  = FRAME_W'($urandom);
    it.upd_bg = 1'($urandom);
    b    = tracker.stored(it.index);
    thr  = tracker.low_thr;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      it.mode = MODE_LOAD;
      if (addr_pool.size() < POOL_TARGET || $urandom_range(0, 3) == 0) begin
        it.index = PIXEL_INDEX_W'($urandom_range(0, DEF_MAX_PIXELS - 1));
        addr_pool.push_back(it.index);
      end
    end else if (kind < 55) begin
      it.mode = MODE_SUBTRACT;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        it.red   = jitter(b[23:16], thr + 1);
        it.green = jitter(b[15:8], thr + 1);
        it.blue  = jitter(b[7:0], thr + 1);
      end else if (pick < 80) begin
        n = $urandom_range(4, 15);
        it.red   = clamp8(int'(b[23:16]) * n / 16);
        it.green = clamp8(int'(b[15:8]) * n / 16);
        it.blue  = clamp8(int'(b[7:0]) * n / 16);
        if (pick >= 65) begin
          it.red   = jitter(it.red, 2);
          it.green = jitter(it.green, 2);
          it.blue  = jitter(it.blue, 2);
        end
      end
    end else if (kind < 92) begin
      it.mode = MODE_UPDATE;
      if ($urandom_range(0, 1)) begin
        it.red   = jitter(b[23:16], 4);
        it.green = jitter(b[15:8], 4);
        it.blue  = jitter(b[7:0], 4);
      end
      pick = $urandom_range(0, 9);
      if (tracker.rate > 1 && pick < 6) begin
        k = $urandom_range(0, 65534 / tracker.rate);
        it.frame = FRAME_W'(k * tracker.rate + 1);
      end else if (pick < 8) begin
        it.frame = FRAME_W'($urandom_range(0, tracker.learn));
      end
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  task automatic send_pixel(pix_item_t it);
    bit taken;
    no_idle = (item_no >= 220 && item_no < 300);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    mode_i                 <= it.mode;
    pixel_index_i          <= it.index;
    red_i                  <= it.red;
    green_i                <= it.green;
    blue_i                 <= it.blue;
    frame_number_i         <= it.frame;
    update_is_background_i <= it.upd_bg;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    tracker.accept_pixel(it);
    item_no++;
  endtask

  task automatic drain_labels();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.label_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(bit [THR_W-1:0] thr, bit [RATE_W-1:0] rate,
                                bit [LEARN_W-1:0] learn);
    cfg_index_t          idx [3];
    bit [CFG_DATA_W-1:0] val [3];
    idx[0] = CFG_LOW_THRESHOLD;
    idx[1] = CFG_SAMPLING_RATE;
    idx[2] = CFG_LEARNING_FRAMES;
    // Upper data bits are junk for the 8-bit registers.
    val[0] = CFG_DATA_W'({8'($urandom), thr});
    val[1] = CFG_DATA_W'({8'($urandom), rate});
    val[2] = CFG_DATA_W'(learn);
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    tracker = new();
    addr_pool.push_back(0);
    addr_pool.push_back(DEF_MAX_PIXELS - 1);
    addr_pool.push_back(32'h0AAAA);
    addr_pool.push_back(32'h15555);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values.
    send_pixel(mk(MODE_LOAD, 0, 0, 0, 0, 0, 1'b0));
    send_pixel(mk(MODE_LOAD, DEF_MAX_PIXELS - 1, 255, 255, 255, 65535, 1'b1));
    send_pixel(mk(MODE_LOAD, 32'h0AAAA, 100, 150, 200, 0, 1'b0));
    send_pixel(mk(MODE_LOAD, 32'h15555, 200, 100, 50, 0, 1'b0));
    // black background: no shadow possible
    send_pixel(mk(MODE_SUBTRACT, 0, 0, 0, 0, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, 0, 255, 255, 255, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, DEF_MAX_PIXELS - 1, 255, 255, 255, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, DEF_MAX_PIXELS - 1, 128, 128, 128, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, DEF_MAX_PIXELS - 1, 0, 0, 0, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, 32'h0AAAA, 50, 75, 100, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, 32'h0AAAA, 110, 160, 210, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, 32'h0AAAA, 121, 150, 200, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, 32'h15555, 20, 10, 5, 0, 1'b0));
    // learning phase, sampled frame, mask low
    send_pixel(mk(MODE_UPDATE, 32'h0AAAA, 255, 0, 200, 1, 1'b0));
    send_pixel(mk(MODE_UPDATE, 32'h0AAAA, 255, 0, 200, 2, 1'b1));
    send_pixel(mk(MODE_UPDATE, 32'h0AAAA, 255, 0, 200, 31, 1'b0));
    send_pixel(mk(MODE_UPDATE, 32'h0AAAA, 255, 0, 200, 31, 1'b1));
    send_pixel(mk(MODE_UPDATE, 32'h15555, 0, 255, 50, 65535, 1'b1));
    send_pixel(mk(MODE_UPDATE, DEF_MAX_PIXELS - 1, 0, 0, 0, 0, 1'b1));
    send_pixel(mk(MODE_SUBTRACT, 32'h0AAAA, 102, 150, 200, 0, 1'b0));
    send_pixel(mk(MODE_SUBTRACT, 32'h15555, 100, 150, 25, 0, 1'b0));
    send_pixel(mk(MODE_UNUSED, 32'h0AAAA, 255, 255, 255, 65535, 1'b1));

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_labels();
      case (phase)
        1: write_settings(8'd0, 8'd1, 16'd0);
        2: write_settings(8'd255, 8'd255, 16'hFFFF);
        3: write_settings(8'd12, 8'd3, 16'd200);
        4: write_settings(8'($urandom), 8'd0, 16'($urandom));
        5: write_settings(8'($urandom_range(0, 40)), 8'($urandom_range(2, 6)),
                          16'($urandom_range(0, 100)));
        default: ;
      endcase
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (item_no == 150) drain_labels();
        if (item_no == 330) hold_req = 1'b1;
        send_pixel(make_random_item());
      end
    end

    drain_labels();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### adaptive_median_background_subtract.f
rtl/core/ambs_pkg.sv
rtl/core/ambs_frame_mod.sv
rtl/core/ambs_model_mem.sv
rtl/core/ambs_classify.sv
rtl/core/adaptive_median_background_subtract.sv
sim/tb_adaptive_median_background_subtract.sv
